// ----- rtl/crc32cc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc32cc_pkg
// Shared constants, types and the 32-bit CRC lookup table for the framed command
// checker.
// ----------------------------------------------------------------------------
package crc32cc_pkg;

  localparam int FRAME_BYTES = 37;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CRC_FIRST = POS_W'(FRAME_BYTES - 4);
  localparam logic [POS_W-1:0] POS_CMD_B0    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CMD_B1    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CMD_B2    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CMD_B3    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PAY_B0    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PAY_B1    = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PAY_B2    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_PAY_B3    = POS_W'(8);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_XOR_TAB = 32'hFF000000;

  localparam int APB_ADDR_W = 5;

  localparam logic [2:0] REG_START_BYTE   = 3'd0;
  localparam logic [2:0] REG_CODE_QUERY   = 3'd1;
  localparam logic [2:0] REG_CODE_ENABLE  = 3'd2;
  localparam logic [2:0] REG_CODE_DISABLE = 3'd3;
  localparam logic [2:0] REG_CODE_SET_PWM = 3'd4;

  localparam logic VERDICT_ACK = 1'b0;
  localparam logic VERDICT_NAK = 1'b1;

  typedef enum logic [2:0] {
    KIND_QUERY   = 3'd0,
    KIND_ENABLE  = 3'd1,
    KIND_DISABLE = 3'd2,
    KIND_SET_PWM = 3'd3,
    KIND_UNKNOWN = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic [31:0] code_query;
    logic [31:0] code_enable;
    logic [31:0] code_disable;
    logic [31:0] code_set_pwm;
  } cmd_codes_t;

  // One finished frame with a good start byte, handed from front to back.
  typedef struct packed {
    logic [31:0] command;
    logic [31:0] payload;
    logic        crc_ok;
  } frame_rec_t;

  typedef logic [31:0] crc_table_t [256];

  function automatic crc_table_t crc_table_build();
    crc_table_t  t;
    logic [31:0] r;
    for (int i = 0; i < 256; i++) begin
      r = 32'(i);
      for (int k = 0; k < 8; k++) begin
        r = (r[0] ? 32'h0 : CRC_POLY) ^ (r >> 1);
      end
      t[i] = r ^ CRC_XOR_TAB;
    end
    return t;
  endfunction

  localparam crc_table_t CRC_TABLE = crc_table_build();

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    return CRC_TABLE[crc[7:0] ^ b] ^ {8'h00, crc[31:8]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/crc32_command_frame_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_command_frame_checker
// Checks fixed-length received command frames (start byte, little-endian
// command, payload, big-endian 32-bit CRC) and gives one ACK/NAK result per frame
// that carried the configured start byte.
//
//   Channel   Handshake              Payload
//   input     push / full            rx_byte
//   result    empty / pop            verdict, command_word, command_kind,
//                                    payload_word
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One byte is accepted per cycle unless full stalls the input; the CRC table
// lookup and update are combinational into the front's CRC register. A frame's
// record is written into the queue at the edge that accepts its last byte and
// then classified into the output register once that is free or popped. full
// rises only on the last byte of a frame, and only when the two-entry record
// queue is full, so the input stalls only when results are not being popped.
// Synchronous reset clears the frame position, queue and result valid;
// configuration registers reset to zero.
// ----------------------------------------------------------------------------
module crc32_command_frame_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [7:0]                         rx_byte,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic                                    verdict,
  output logic [31:0]                             command_word,
  output logic [2:0]                              command_kind,
  output logic [31:0]                             payload_word,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [crc32cc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  logic [7:0]                 start_byte;
  crc32cc_pkg::cmd_codes_t    codes;
  logic [2:0]                 reg_idx;
  logic                       reg_wr;
  logic                       q_push;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  crc32cc_pkg::frame_rec_t    q_rec;
  crc32cc_pkg::frame_rec_t    q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[crc32cc_pkg::APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'h00;
      codes      <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        crc32cc_pkg::REG_START_BYTE:   start_byte         <= pwdata[7:0];
        crc32cc_pkg::REG_CODE_QUERY:   codes.code_query   <= pwdata;
        crc32cc_pkg::REG_CODE_ENABLE:  codes.code_enable  <= pwdata;
        crc32cc_pkg::REG_CODE_DISABLE: codes.code_disable <= pwdata;
        crc32cc_pkg::REG_CODE_SET_PWM: codes.code_set_pwm <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      crc32cc_pkg::REG_START_BYTE:   prdata = {24'h0, start_byte};
      crc32cc_pkg::REG_CODE_QUERY:   prdata = codes.code_query;
      crc32cc_pkg::REG_CODE_ENABLE:  prdata = codes.code_enable;
      crc32cc_pkg::REG_CODE_DISABLE: prdata = codes.code_disable;
      crc32cc_pkg::REG_CODE_SET_PWM: prdata = codes.code_set_pwm;
      default:                       prdata = 32'h0;
    endcase
  end

  crc32cc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .start_byte (start_byte),
    .q_push     (q_push),
    .q_rec      (q_rec),
    .q_full     (q_full)
  );

  crc32cc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_rec   (q_rec),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  crc32cc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .codes        (codes),
    .pop          (pop),
    .empty        (empty),
    .verdict      (verdict),
    .command_word (command_word),
    .command_kind (command_kind),
    .payload_word (payload_word)
  );

endmodule
`default_nettype wire

// ----- rtl/crc32cc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc32cc_front
// Takes one byte per cycle unless full stalls the last byte, tracks the frame
// position, runs the CRC and assembles the command, payload and trailing CRC.
// Hands a record of each frame with a good start byte to the queue.
// ----------------------------------------------------------------------------
module crc32cc_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [7:0]              rx_byte,
  input  wire logic [7:0]              start_byte,
  output logic                         q_push,
  output crc32cc_pkg::frame_rec_t      q_rec,
  input  wire logic                    q_full
);

  logic [crc32cc_pkg::POS_W-1:0] pos;
  logic                          start_ok;
  logic [31:0]                   crc;
  logic [31:0]                   rcv_crc;
  logic [31:0]                   command;
  logic [31:0]                   payload;
  logic [31:0]                   crc_cur;
  logic [31:0]                   rcv_full;
  logic                          at_last;
  logic                          accept;

  // Only the last byte of a frame needs room in the queue.
  assign at_last  = (pos == crc32cc_pkg::POS_LAST);
  assign full     = at_last && q_full;
  assign accept   = push && !full;
  assign crc_cur  = (pos == '0) ? 32'h0 : crc;
  assign rcv_full = {rcv_crc[23:0], rx_byte};

  assign q_push         = accept && at_last && start_ok;
  assign q_rec.command  = command;
  assign q_rec.payload  = payload;
  assign q_rec.crc_ok   = (crc == rcv_full) && (rcv_full != 32'h0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      start_ok <= 1'b0;
    end else if (accept) begin
      pos <= at_last ? '0 : pos + 1'b1;
      if (pos == '0) begin
        start_ok <= (rx_byte == start_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos < crc32cc_pkg::POS_CRC_FIRST) begin
        crc <= crc32cc_pkg::crc_step(crc_cur, rx_byte);
      end else begin
        rcv_crc <= rcv_full;
      end
      if (pos == crc32cc_pkg::POS_CMD_B0) command[7:0]   <= rx_byte;
      if (pos == crc32cc_pkg::POS_CMD_B1) command[15:8]  <= rx_byte;
      if (pos == crc32cc_pkg::POS_CMD_B2) command[23:16] <= rx_byte;
      if (pos == crc32cc_pkg::POS_CMD_B3) command[31:24] <= rx_byte;
      if (pos == crc32cc_pkg::POS_PAY_B0) payload[7:0]   <= rx_byte;
      if (pos == crc32cc_pkg::POS_PAY_B1) payload[15:8]  <= rx_byte;
      if (pos == crc32cc_pkg::POS_PAY_B2) payload[23:16] <= rx_byte;
      if (pos == crc32cc_pkg::POS_PAY_B3) payload[31:24] <= rx_byte;
    end
  end

`ifndef ASSERT_OFF
  a_full_only_at_last: assert property (@(posedge clk) disable iff (rst)
    full |-> at_last)
    else $error("front stalls away from the last byte of a frame");
  a_push_only_at_last: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (pos == '0))
    else $error("frame record pushed without the position wrapping");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("frame record pushed into a full queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/crc32cc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc32cc_queue
// Short queue of finished frame records between the front and the back.
// ----------------------------------------------------------------------------
module crc32cc_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_push,
  input  crc32cc_pkg::frame_rec_t      q_rec,
  output logic                         q_full,
  output logic                         q_empty,
  input  wire logic                    q_pop,
  output crc32cc_pkg::frame_rec_t      q_head
);

  crc32cc_pkg::frame_rec_t                 mem [crc32cc_pkg::QUEUE_DEPTH];
  logic [crc32cc_pkg::QPTR_W-1:0]          wr_ptr;
  logic [crc32cc_pkg::QPTR_W-1:0]          rd_ptr;
  logic [crc32cc_pkg::QCNT_W-1:0]          count;
  logic                                    do_push;
  logic                                    do_pop;

  localparam logic [crc32cc_pkg::QPTR_W-1:0] PTR_LAST =
    crc32cc_pkg::QPTR_W'(crc32cc_pkg::QUEUE_DEPTH - 1);
  localparam logic [crc32cc_pkg::QCNT_W-1:0] CNT_FULL =
    crc32cc_pkg::QCNT_W'(crc32cc_pkg::QUEUE_DEPTH);

  assign q_full  = (count == CNT_FULL);
  assign q_empty = (count == '0);
  assign q_head  = mem[rd_ptr];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= q_rec;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");
`endif

endmodule
`default_nettype wire

// ----- rtl/crc32cc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crc32cc_back
// Classifies the command of the oldest frame record against the configured
// codes, decides ACK or NAK, and holds the result in an output register.
// ----------------------------------------------------------------------------
module crc32cc_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  input  crc32cc_pkg::frame_rec_t      q_head,
  output logic                         q_pop,
  input  crc32cc_pkg::cmd_codes_t      codes,
  input  wire logic                    pop,
  output logic                         empty,
  output logic                         verdict,
  output logic [31:0]                  command_word,
  output logic [2:0]                   command_kind,
  output logic [31:0]                  payload_word
);

  logic                      out_valid;
  crc32cc_pkg::cmd_kind_t    kind;
  logic                      ack;

  // First matching code wins when codes are equal.
  always_comb begin
    if (q_head.command == codes.code_query) begin
      kind = crc32cc_pkg::KIND_QUERY;
    end else if (q_head.command == codes.code_enable) begin
      kind = crc32cc_pkg::KIND_ENABLE;
    end else if (q_head.command == codes.code_disable) begin
      kind = crc32cc_pkg::KIND_DISABLE;
    end else if (q_head.command == codes.code_set_pwm) begin
      kind = crc32cc_pkg::KIND_SET_PWM;
    end else begin
      kind = crc32cc_pkg::KIND_UNKNOWN;
    end
  end

  assign ack   = q_head.crc_ok && (kind != crc32cc_pkg::KIND_UNKNOWN);
  assign q_pop = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      verdict      <= ack ? crc32cc_pkg::VERDICT_ACK : crc32cc_pkg::VERDICT_NAK;
      command_word <= q_head.command;
      command_kind <= ack ? 3'(kind) : 3'(crc32cc_pkg::KIND_UNKNOWN);
      payload_word <= q_head.payload;
    end
  end

`ifndef ASSERT_OFF
  a_ack_known: assert property (@(posedge clk) disable iff (rst)
    (!empty && verdict == crc32cc_pkg::VERDICT_ACK)
      |-> (command_kind != 3'(crc32cc_pkg::KIND_UNKNOWN)))
    else $error("ACK result with unknown command kind");
  a_nak_unknown: assert property (@(posedge clk) disable iff (rst)
    (!empty && verdict == crc32cc_pkg::VERDICT_NAK)
      |-> (command_kind == 3'(crc32cc_pkg::KIND_UNKNOWN)))
    else $error("NAK result with a known command kind");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |-> !q_pop)
    else $error("waiting result overwritten by the next record");
`endif

endmodule
`default_nettype wire
